[rtl/msk_pkg.sv]
// Package for the minimum-tracking stack: action and status codes, the
// controller command and datapath flag structs. No dependencies.
`default_nettype none

package msk_pkg;

	localparam int FIELD_BITS = 32;

	// Action codes of a request beat
	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	// Status codes of a response beat
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH,
		OP_OVERFLOW,
		OP_UNDERFLOW,
		OP_PEEK,
		OP_POP_LAST,
		OP_POP_START,
		OP_POP_FINISH
	} msk_op_t;

	typedef struct packed {
		msk_op_t op;
	} msk_cmd_t;

	typedef struct packed {
		logic empty;
		logic single;
		logic full;
	} msk_flags_t;

endpackage

`default_nettype wire

[rtl/msk_if.sv]
// Stream interfaces for request and response beats of the stack.
// Depend on msk_pkg for the field width.
`default_nettype none

interface msk_in_if import msk_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic signed [FIELD_BITS-1:0] push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink (input valid, input action, input push_value, output ready);
endinterface

interface msk_out_if import msk_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [FIELD_BITS-1:0] top_value;
	logic signed [FIELD_BITS-1:0] current_min;
	logic                         is_empty;
	logic [1:0]                   status;

	modport source (output valid, output top_value, output current_min, output is_empty,
		output status, input ready);
	modport sink (input valid, input top_value, input current_min, input is_empty,
		input status, output ready);
endinterface

`default_nettype wire

[rtl/min_tracking_stack.sv]
// Top level of the minimum-tracking stack: controller, datapath and the
// request/response stream ports. Depends on msk_pkg, msk_if, msk_ctrl, msk_dp.
`default_nettype none

// A bounded stack of signed words that reports the minimum of its contents
// with every response. Each request beat carries a push, a pop or a peek
// (the unused action code acts as a peek) and yields exactly one response
// beat: the popped or peeked word, the minimum after the operation, an empty
// flag and a status (overflow on a push to a full stack, which is dropped;
// empty on a pop or peek of an empty stack). The top entry and its running
// minimum sit in registers, the entries below in a RAM with a registered
// read port. Push, peek, errors and a pop of the last entry write their
// response directly, so a new request is taken every cycle; a pop that
// leaves entries behind needs a reload state, since the new top and its
// minimum are first fetched from the RAM, and the request port is held
// off in that state. The single response register takes the next request
// in the same cycle that the previous response beat is taken; while a
// response waits, the request port stalls. No clearing pass is needed
// after reset: entries are only read below the occupancy count.

module min_tracking_stack import msk_pkg::*; #(
	parameter int STACK_DEPTH = 32,
	parameter int WORD_BITS   = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	msk_in_if.sink     req,
	msk_out_if.source  rsp
);

	msk_cmd_t   cmd;
	msk_flags_t flags;

	// handshakes, decode and the reload step of a deep pop
	msk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.action   (req.action),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.flags    (flags),
		.cmd      (cmd)
	);

	// occupancy, cached top entry, entry RAM and response payload
	msk_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (req.push_value),
		.flags      (flags),
		.top_value  (rsp.top_value),
		.current_min(rsp.current_min),
		.is_empty   (rsp.is_empty),
		.status     (rsp.status)
	);

endmodule

`default_nettype wire

[rtl/msk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msk_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/msk_ctrl.sv]
// Controller of the stack: handshakes, operation decode and the reload state.
// Depends on msk_pkg.
`default_nettype none

module msk_ctrl import msk_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [1:0] action,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	input  wire msk_flags_t flags,
	output msk_cmd_t        cmd
);

	typedef enum logic {
		S_IDLE,
		S_RELOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   result_now;

	assign req_ready = (state_q == S_IDLE) && (!out_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.op = OP_NONE;
		if (state_q == S_RELOAD) begin
			cmd.op = OP_POP_FINISH;
		end else if (accept) begin
			unique case (action)
				ACT_PUSH: cmd.op = flags.full ? OP_OVERFLOW : OP_PUSH;
				ACT_POP: begin
					if (flags.empty) cmd.op = OP_UNDERFLOW;
					else if (flags.single) cmd.op = OP_POP_LAST;
					else cmd.op = OP_POP_START;
				end
				default: cmd.op = flags.empty ? OP_UNDERFLOW : OP_PEEK;
			endcase
		end
	end

	// every operation but the start of a deep pop yields its response at once
	assign result_now = (cmd.op != OP_NONE) && (cmd.op != OP_POP_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= (cmd.op == OP_POP_START) ? S_RELOAD : S_IDLE;
			if (result_now) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	ap_reload_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RELOAD |=> state_q == S_IDLE && out_valid_q)
		else $error("reload did not finish in one cycle");

	ap_reload_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RELOAD |-> !out_valid_q)
		else $error("response register busy during reload");

endmodule

`default_nettype wire

[rtl/msk_dp.sv]
// Datapath of the stack: occupancy, cached top entry, entry RAM and the
// response register. Depends on msk_pkg and msk_ram.
`default_nettype none

module msk_dp import msk_pkg::*; #(
	parameter int STACK_DEPTH = 32,
	parameter int WORD_BITS   = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire msk_cmd_t                     cmd,
	input  wire logic signed [FIELD_BITS-1:0] push_value,
	output msk_flags_t                        flags,
	output logic signed [FIELD_BITS-1:0]      top_value,
	output logic signed [FIELD_BITS-1:0]      current_min,
	output logic                              is_empty,
	output logic [1:0]                        status
);

	localparam int OCC_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	logic [OCC_W-1:0]            occ_q;
	logic signed [WORD_BITS-1:0] top_val_q;
	logic signed [WORD_BITS-1:0] top_min_q;
	logic signed [WORD_BITS-1:0] push_word;
	logic signed [WORD_BITS-1:0] push_min;
	logic [2*WORD_BITS-1:0]      rd_data;
	logic signed [WORD_BITS-1:0] rd_val;
	logic signed [WORD_BITS-1:0] rd_min;
	logic [OCC_W-1:0]            below_top;

	assign flags.empty  = (occ_q == '0);
	assign flags.single = (occ_q == OCC_W'(1));
	assign flags.full   = (occ_q == OCC_W'(STACK_DEPTH));

	assign push_word = WORD_BITS'(push_value);
	assign push_min  = (!flags.empty && (top_min_q < push_word)) ? top_min_q : push_word;
	assign rd_val    = rd_data[2*WORD_BITS-1:WORD_BITS];
	assign rd_min    = rd_data[WORD_BITS-1:0];
	assign below_top = occ_q - OCC_W'(2);

	msk_ram #(
		.WIDTH(2 * WORD_BITS),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.op == OP_PUSH),
		.wr_addr(occ_q[ADDR_W-1:0]),
		.wr_data({push_word, push_min}),
		.rd_en  (cmd.op == OP_POP_START),
		.rd_addr(below_top[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_PUSH: occ_q <= occ_q + OCC_W'(1);
				OP_POP_LAST, OP_POP_START: occ_q <= occ_q - OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	// cached top entry and response payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_PUSH: begin
				top_val_q   <= push_word;
				top_min_q   <= push_min;
				top_value   <= '0;
				current_min <= FIELD_BITS'(push_min);
				is_empty    <= 1'b0;
				status      <= ST_OK;
			end
			OP_OVERFLOW: begin
				top_value   <= '0;
				current_min <= FIELD_BITS'(top_min_q);
				is_empty    <= 1'b0;
				status      <= ST_OVERFLOW;
			end
			OP_UNDERFLOW: begin
				top_value   <= '0;
				current_min <= '0;
				is_empty    <= 1'b1;
				status      <= ST_EMPTY;
			end
			OP_PEEK: begin
				top_value   <= FIELD_BITS'(top_val_q);
				current_min <= FIELD_BITS'(top_min_q);
				is_empty    <= 1'b0;
				status      <= ST_OK;
			end
			OP_POP_LAST: begin
				top_value   <= FIELD_BITS'(top_val_q);
				current_min <= '0;
				is_empty    <= 1'b1;
				status      <= ST_OK;
			end
			OP_POP_START: begin
				top_value <= FIELD_BITS'(top_val_q);
			end
			OP_POP_FINISH: begin
				top_val_q   <= rd_val;
				top_min_q   <= rd_min;
				current_min <= FIELD_BITS'(rd_min);
				is_empty    <= 1'b0;
				status      <= ST_OK;
			end
			default: begin
			end
		endcase
	end

	ap_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(STACK_DEPTH))
		else $error("occupancy beyond stack depth");

	ap_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PUSH |=> occ_q == $past(occ_q) + OCC_W'(1))
		else $error("push did not grow the stack");

endmodule

`default_nettype wire
